// ===== hdl/vnr_pkg.sv =====
// Shared types and constants of the vector normalization factor block.
// Used by the sequencer and the top level; depends on nothing.

package vnr_pkg;

    // Result and iteration widths; fixed by the Q16.16 factor format.
    localparam int FACTOR_W   = 32;
    localparam int ROOT_W     = 32;
    localparam int QUOT_W     = 65;
    localparam int CNT_W      = 7;
    localparam int MIN_UNIT_W = 35;

    // Normalization modes.
    localparam logic MODE_L1         = 1'b0;
    localparam logic MODE_L2         = 1'b1;
    localparam logic NORM_MODE_RESET = MODE_L2;

    // Iteration counts: quotient bits 2^32/T or 2^64/T, then root bits.
    localparam logic [CNT_W-1:0] L1_DIV_TOP = 7'd32;
    localparam logic [CNT_W-1:0] L2_DIV_TOP = 7'd64;
    localparam logic [CNT_W-1:0] SQRT_TOP   = 7'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic item_last;
        logic item_l2;
        logic total_zero;
        logic out_free;
    } vnr_status_t;

    typedef struct packed {
        logic s_ready;
        logic take_item;
        logic acc_add;
        logic div_init;
        logic div_step;
        logic div_first;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
    } vnr_ctrl_t;

endpackage

// ===== hdl/vnr_cmpsub.sv =====
// Shared compare-and-subtract unit of the divider and the square root.
// Purely combinational; no package dependency.

module vnr_cmpsub #(
    parameter int W = 65
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         ge,
    output logic [W-1:0] diff
);

    logic [W:0] wide_diff;

    // Borrow out of the top bit means a < b.
    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign ge        = ~wide_diff[W];
    assign diff      = wide_diff[W-1:0];

endmodule

// ===== hdl/vnr_ctrl.sv =====
// Sequencer of the vector normalization factor block: state, step counter
// and control strobes. Depends on vnr_pkg.

module vnr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  vnr_pkg::vnr_status_t status,
    output vnr_pkg::vnr_ctrl_t   ctrl
);

    import vnr_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cnt_zero;
    logic [CNT_W-1:0] div_top;

    assign cnt_zero = (cnt_reg == '0);
    assign div_top  = status.item_l2 ? L2_DIV_TOP : L1_DIV_TOP;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!status.item_last) begin
                    state_next = ST_IDLE;
                end else if (status.total_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_zero) begin
                    state_next = status.item_l2 ? ST_SQRT : ST_DONE;
                end
            end
            ST_SQRT: begin
                if (cnt_zero) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctrl.s_ready   = 1'b1;
                ctrl.take_item = s_valid;
            end
            ST_ACC: begin
                ctrl.acc_add  = 1'b1;
                ctrl.div_init = status.item_last & ~status.total_zero;
            end
            ST_DIV: begin
                ctrl.div_step  = 1'b1;
                ctrl.div_first = (cnt_reg == div_top);
                ctrl.sqrt_init = cnt_zero & status.item_l2;
            end
            ST_SQRT: begin
                ctrl.sqrt_step = 1'b1;
            end
            ST_DONE: begin
                ctrl.out_load = status.out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.sqrt_init) begin
            cnt_next = SQRT_TOP;
        end else if (ctrl.div_init) begin
            cnt_next = div_top;
        end else if ((ctrl.div_step || ctrl.sqrt_step) && !cnt_zero) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/vector_norm_reciprocal.sv =====
// Top level of the vector normalization factor block: accumulator, divider
// and square-root registers around one shared compare-subtract unit.
// Depends on vnr_pkg, vnr_cmpsub and vnr_ctrl.

// Takes the unsigned Q8.16 weights of one word vector, one request per weight,
// and sums either the weights (norm_mode 0, L1) or their squares (norm_mode 1,
// L2, the reset value) in a saturating accumulator. On the weight marked
// last it returns one result: the Q16.16 factor floor(2^32/T) in L1 mode or
// floor(2^32/sqrt(T)) in L2 mode, saturated at 0xFFFFFFFF, then clears the
// accumulator; a zero total gives factor 0 with zero_total set. Each weight
// is summed under the mode in force when it is accepted, and the factor uses
// the mode of the last weight. A weight that is not last is accepted, then
// accumulated. A last weight is accepted and accumulated, then the shared
// compare-subtract unit gives one quotient bit per cycle, then one root bit
// per cycle in L2, then the output register is loaded; a zero total goes
// straight to the load. Input is not ready during that work. The output
// register holds a result until it is taken while later weights are
// accepted; a new result waits in the done state until the output register
// is free. The user must see that norm_mode is written through the cfg port
// only while the block is idle; the block itself does not enforce this.

module vector_norm_reciprocal #(
    parameter int WEIGHT_WIDTH = 24,
    parameter int ACC_WIDTH    = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    // weight requests
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [WEIGHT_WIDTH-1:0] s_weight_value,
    input  logic                    s_last_entry,
    // result requests
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [31:0]             m_norm_factor,
    output logic                    m_zero_total
);

    import vnr_pkg::*;

    localparam int PROD_W = 2 * WEIGHT_WIDTH;
    localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
    localparam int UNIT_W = (ACC_WIDTH + 1 > MIN_UNIT_W) ? ACC_WIDTH + 1 : MIN_UNIT_W;

    vnr_ctrl_t   ctrl;
    vnr_status_t status;

    // Mode register.
    logic norm_mode_reg;
    logic norm_mode_next;

    // Accepted item.
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] weight_sq;
    logic              item_last_reg;
    logic              item_l2_reg;

    // Accumulator.
    logic [ACC_WIDTH-1:0] acc_reg;
    logic [ACC_WIDTH-1:0] acc_next;
    logic [SUM_W-1:0]     acc_sum;
    logic [ACC_WIDTH-1:0] acc_sum_sat;

    // Divider and square-root registers.
    logic [UNIT_W-1:0] rem_reg;
    logic [UNIT_W-1:0] rem_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [UNIT_W-1:0] rem_div_sh;
    logic [UNIT_W-1:0] rem_sq_sh;
    logic [UNIT_W-1:0] divisor;
    logic [UNIT_W-1:0] trial;

    // Shared unit.
    logic [UNIT_W-1:0] unit_a;
    logic [UNIT_W-1:0] unit_b;
    logic [UNIT_W-1:0] unit_diff;
    logic              unit_ge;

    // Output register.
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [FACTOR_W-1:0] factor_reg;
    logic                zero_reg;
    logic [FACTOR_W-1:0] factor_out;
    logic                total_is_zero;

    vnr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .ctrl    (ctrl)
    );

    vnr_cmpsub #(
        .W (UNIT_W)
    ) u_cmpsub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign cfg_ready     = 1'b1;
    assign s_ready       = ctrl.s_ready;
    assign m_valid       = m_valid_reg;
    assign m_norm_factor = factor_reg;
    assign m_zero_total  = zero_reg;

    always_comb begin
        norm_mode_next = norm_mode_reg;
        if (cfg_valid && cfg_ready) begin
            norm_mode_next = cfg_data;
        end
    end

    // Square at the input, registered before the accumulate cycle.
    assign weight_sq = PROD_W'(s_weight_value) * PROD_W'(s_weight_value);
    assign prod_next = (norm_mode_reg == MODE_L2) ? weight_sq : PROD_W'(s_weight_value);

    // Saturating accumulate; clip anything above the accumulator's range.
    assign acc_sum     = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    assign acc_sum_sat = (acc_sum > SUM_W'({ACC_WIDTH{1'b1}})) ? {ACC_WIDTH{1'b1}}
                                                               : acc_sum[ACC_WIDTH-1:0];

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.out_load) begin
            acc_next = '0;
        end else if (ctrl.acc_add) begin
            acc_next = acc_sum_sat;
        end
    end

    assign status.item_last  = item_last_reg;
    assign status.item_l2    = item_l2_reg;
    assign status.total_zero = (acc_sum_sat == '0);
    assign status.out_free   = ~m_valid_reg | m_ready;

    // Restoring division of a power of two: shift in a one on the first step.
    assign rem_div_sh = {rem_reg[UNIT_W-2:0], ctrl.div_first};
    assign divisor    = {{(UNIT_W-ACC_WIDTH){1'b0}}, acc_reg};
    // Digit-by-digit root: two bits of the quotient per step.
    assign rem_sq_sh  = {rem_reg[UNIT_W-3:0], quot_reg[QUOT_W-2:QUOT_W-3]};
    assign trial      = {{(UNIT_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};

    assign unit_a = ctrl.sqrt_step ? rem_sq_sh : rem_div_sh;
    assign unit_b = ctrl.sqrt_step ? trial : divisor;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        root_next = root_reg;
        if (ctrl.div_init) begin
            rem_next  = '0;
            quot_next = '0;
        end
        if (ctrl.div_step) begin
            rem_next  = unit_ge ? unit_diff : rem_div_sh;
            quot_next = {quot_reg[QUOT_W-2:0], unit_ge};
        end
        if (ctrl.sqrt_step) begin
            rem_next  = unit_ge ? unit_diff : rem_sq_sh;
            // Keep the top bit: it flags a quotient too large for the root.
            quot_next = {quot_reg[QUOT_W-1], quot_reg[QUOT_W-4:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], unit_ge};
        end
        if (ctrl.sqrt_init) begin
            rem_next  = '0;
            root_next = '0;
        end
    end

    // Final factor with saturation.
    assign total_is_zero = (acc_reg == '0);

    always_comb begin
        if (total_is_zero) begin
            factor_out = '0;
        end else if (item_l2_reg == MODE_L1) begin
            factor_out = (|quot_reg[QUOT_W-1:FACTOR_W]) ? {FACTOR_W{1'b1}}
                                                        : quot_reg[FACTOR_W-1:0];
        end else begin
            factor_out = quot_reg[QUOT_W-1] ? {FACTOR_W{1'b1}} : root_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_mode_reg <= NORM_MODE_RESET;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            norm_mode_reg <= norm_mode_next;
            acc_reg       <= acc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers: hold unless loaded.
    always_ff @(posedge aclk) begin
        if (ctrl.take_item) begin
            prod_reg      <= prod_next;
            item_last_reg <= s_last_entry;
            item_l2_reg   <= norm_mode_reg;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        root_reg <= root_next;
        if (ctrl.out_load) begin
            factor_reg <= factor_out;
            zero_reg   <= total_is_zero;
        end
    end

`ifndef SYNTHESIS
    // A zero total always comes with a zero factor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_total |-> m_norm_factor == '0)
        else $error("zero total with nonzero factor");

    // Drop the total once its result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |=> acc_reg == '0)
        else $error("accumulator not cleared after result");

    // One request in flight: no accept in the cycle after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready while a weight is being summed");

    // A result loads only into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> !m_valid || m_ready)
        else $error("result overwrote a pending result");
`endif

endmodule
